// ===== rtl/core/assert_macros.svh =====
// shared assertion shorthands for the tilt detector checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// next-cycle implication that also runs through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

// ===== rtl/core/itd_pkg.sv =====
package itd_pkg;

    localparam int CAL_SAMPLES = 50;

    localparam int NUM_GYRO  = 3;
    localparam int NUM_AXES  = NUM_GYRO + 1;
    localparam int RAW_W     = 16;
    localparam int FRAC_BITS = 8;
    localparam int AVG_W     = RAW_W + FRAC_BITS;
    localparam int CENT_W    = AVG_W + 1;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int DECAY_P_W = AVG_W + GAIN_W + 1;
    localparam int INPUT_P_W = CENT_W + GAIN_W + 1;
    localparam int ACC_W     = INPUT_P_W;
    localparam int SUM_W     = 56;
    localparam int SUM_EXT_W = SUM_W + 1;
    localparam int CNT_W     = 32;
    localparam int RUN_W     = 16;
    localparam int CAL_IDX_W = 8;

    // offset mean by reciprocal multiplication: the shift leaves enough headroom that
    // floor(|sum| * 2^FRAC_BITS / CAL_SAMPLES) is exact for any sum of CAL_SAMPLES raw samples
    localparam int     DIV_LOG     = $clog2(CAL_SAMPLES);
    localparam int     RECIP_SHIFT = RAW_W - 1 + FRAC_BITS + 2 * DIV_LOG;
    localparam int     RECIP_W     = RECIP_SHIFT - DIV_LOG + 1;
    localparam int     PROD_W      = AVG_W + RECIP_W;
    localparam int     QUOT_LSB    = RECIP_SHIFT - FRAC_BITS;
    localparam int     QUOT_W      = AVG_W + 1;
    localparam int     LANE_W      = $clog2(NUM_AXES);
    localparam longint RECIP_VAL   = ((longint'(1) << RECIP_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(RECIP_VAL);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 248;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (AVG_W + RUN_W + 3 + NUM_GYRO * SUM_W + CNT_W);

    localparam logic [GAIN_W-1:0]        DECAY_GAIN_RST     = 16'd29491;
    localparam logic [GAIN_W-1:0]        INPUT_GAIN_RST     = 16'd3277;
    localparam logic signed [RAW_W-1:0]  TILT_THRESHOLD_RST = -16'sd819;
    localparam logic [RUN_W-1:0]         COUNT_LIMIT_RST    = 16'd10;

    typedef logic signed [AVG_W-1:0] t_fix;
    typedef logic signed [SUM_W-1:0] t_sum;

    localparam t_sum SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};
    localparam t_fix AVG_MAX = {1'b0, {(AVG_W - 1){1'b1}}};
    localparam t_fix AVG_MIN = {1'b1, {(AVG_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_CAL    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_GAIN     = 3'd0,
        CFG_INPUT_GAIN     = 3'd1,
        CFG_TILT_THRESHOLD = 3'd2,
        CFG_COUNT_LIMIT    = 3'd3,
        CFG_LED_ENABLE     = 3'd4,
        CFG_DETECT_ENABLE  = 3'd5
    } t_cfg_index;

    // samples already scaled to 8 fraction bits
    typedef struct packed {
        t_cmd                 cmd;
        t_fix                 accel;
        t_fix [NUM_GYRO-1:0]  gyro;
    } t_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [CNT_W-1:0]     sample_count;
        t_sum                 gyro_sum_z;
        t_sum                 gyro_sum_y;
        t_sum                 gyro_sum_x;
        logic                 calibrating;
        logic                 led_state;
        logic                 tilted;
        logic [RUN_W-1:0]     below_count;
        t_fix                 mean_tilt;
    } t_result;

endpackage

// ===== rtl/core/itd_front.sv =====
module itd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [itd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // accel_y, gyro_x, gyro_y, gyro_z
    input  logic [itd_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // cmd
    input  logic                            i_q_ready,
    output logic                            o_push,
    output itd_pkg::t_item                  o_item
);
    import itd_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // decode the command and move the raw samples onto the 8-bit fraction grid
    always_comb begin
        n_item.cmd   = t_cmd'(s_axis_tuser);
        n_item.accel = {s_axis_tdata[RAW_W-1:0], {FRAC_BITS{1'b0}}};
        for (int i = 0; i < NUM_GYRO; i++) begin
            n_item.gyro[i] = {s_axis_tdata[(i + 1) * RAW_W +: RAW_W], {FRAC_BITS{1'b0}}};
        end
    end

    assign s_axis_tready = !r_valid || i_q_ready;
    assign o_push        = r_valid && i_q_ready;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/core/itd_queue.sv =====
module itd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  itd_pkg::t_item  i_item,
    output logic            o_ready,
    output logic            o_valid,
    output itd_pkg::t_item  o_item,
    input  logic            i_pop
);
    import itd_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

// ===== rtl/core/itd_offset_div.sv =====
module itd_offset_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  itd_pkg::t_fix [itd_pkg::NUM_AXES-1:0]   i_sum,
    output itd_pkg::t_div_stat                      o_stat,
    output itd_pkg::t_fix [itd_pkg::NUM_AXES-1:0]   o_quot
);
    import itd_pkg::*;

    // one axis per cycle through a shared reciprocal multiplier
    logic [AVG_W-1:0]      r_mag [NUM_AXES];
    logic [NUM_AXES-1:0]   r_neg;
    t_fix [NUM_AXES-1:0]   r_quot;
    logic [LANE_W-1:0]     r_lane;
    logic                  r_busy;
    logic                  r_done;
    logic signed [AVG_W:0] wide [NUM_AXES];
    logic signed [AVG_W:0] mag [NUM_AXES];
    logic [PROD_W-1:0]     prod;
    logic [QUOT_W-1:0]     quot_mag;
    logic [QUOT_W-1:0]     quot_signed;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            wide[i] = {i_sum[i][AVG_W-1], i_sum[i]};
            mag[i]  = wide[i][AVG_W] ? -wide[i] : wide[i];
        end
        // truncation toward zero: scale the magnitude, then restore the sign
        prod        = PROD_W'(r_mag[r_lane]) * PROD_W'(DIV_RECIP);
        quot_mag    = prod[QUOT_LSB +: QUOT_W];
        quot_signed = r_neg[r_lane] ? (~quot_mag + QUOT_W'(1)) : quot_mag;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_lane <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_lane <= '0;
        end else if (r_busy) begin
            r_lane <= r_lane + LANE_W'(1);
            if (r_lane == LANE_W'(NUM_AXES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_AXES; i++) begin
            if (i_start) begin
                r_mag[i] <= mag[i][AVG_W-1:0];
                r_neg[i] <= i_sum[i][AVG_W-1];
            end
        end
        if (r_busy) begin
            r_quot[r_lane] <= quot_signed[AVG_W-1:0];
        end
    end

endmodule

// ===== rtl/core/itd_back.sv =====
module itd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [itd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [itd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_q_valid,
    input  itd_pkg::t_item                  i_item,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output itd_pkg::t_result                o_result
);
    import itd_pkg::*;

    // configuration
    logic [GAIN_W-1:0]        r_decay_gain;
    logic [GAIN_W-1:0]        r_input_gain;
    logic signed [RAW_W-1:0]  r_tilt_threshold;
    logic [RUN_W-1:0]         r_count_limit;
    logic                     r_led_enable;
    logic                     r_detect_enable;

    // execute-stage state
    t_fix                     r_avg;
    t_fix                     n_avg;
    logic                     r_cal_active;
    logic                     n_cal_active;
    logic [CAL_IDX_W-1:0]     r_cal_idx;
    logic [CAL_IDX_W-1:0]     n_cal_idx;
    t_fix [NUM_AXES-1:0]      r_cal_acc;
    t_fix [NUM_AXES-1:0]      n_cal_acc;
    t_fix [NUM_AXES-1:0]      r_offset;
    t_fix [NUM_AXES-1:0]      n_offset;
    t_sum [NUM_GYRO-1:0]      r_gsum;
    t_sum [NUM_GYRO-1:0]      n_gsum;
    logic [CNT_W-1:0]         r_scount;
    logic [CNT_W-1:0]         n_scount;

    // run-length stage
    logic                     r_mid_valid;
    logic                     r_mid_upd;
    logic                     n_upd;
    logic [RUN_W-1:0]         r_run;
    logic [RUN_W-1:0]         n_run;
    logic                     r_led;
    logic                     n_led;
    logic                     r_out_valid;
    t_result                  r_out;
    t_result                  n_out;

    logic                     adv;
    logic                     pop;
    logic                     div_start;
    t_div_stat                div_stat;
    t_fix [NUM_AXES-1:0]      div_quot;

    t_sum                     corr [NUM_GYRO];
    logic signed [SUM_EXT_W-1:0] gwide [NUM_GYRO];
    logic signed [CENT_W-1:0] centred;
    logic signed [GAIN_W:0]   decay_s;
    logic signed [GAIN_W:0]   input_s;
    logic signed [DECAY_P_W-1:0] mul_decay;
    logic signed [INPUT_P_W-1:0] mul_input;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  shifted;
    t_fix                     thr_fix;
    logic                     below;
    logic                     tilted;

    itd_offset_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (n_cal_acc),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    assign adv   = !r_out_valid || i_tready;
    assign pop   = (!r_mid_valid || adv) && i_q_valid && !div_stat.busy && !div_stat.done;
    assign o_pop = pop;

    // leaky average datapath
    always_comb begin
        centred   = CENT_W'(i_item.accel) - CENT_W'(r_offset[0]);
        decay_s   = $signed({1'b0, r_decay_gain});
        input_s   = $signed({1'b0, r_input_gain});
        mul_decay = r_avg * decay_s;
        mul_input = centred * input_s;
        acc_sum   = ACC_W'(mul_decay) + ACC_W'(mul_input);
        shifted   = acc_sum >>> GAIN_FRAC;
    end

    // gyro sums with saturation
    always_comb begin
        for (int i = 0; i < NUM_GYRO; i++) begin
            corr[i]  = SUM_W'($signed(i_item.gyro[i])) - SUM_W'(r_offset[i + 1]);
            gwide[i] = SUM_EXT_W'(r_gsum[i]) + SUM_EXT_W'(corr[i]);
        end
    end

    always_comb begin
        n_avg        = r_avg;
        n_cal_active = r_cal_active;
        n_cal_idx    = r_cal_idx;
        n_cal_acc    = r_cal_acc;
        n_offset     = r_offset;
        n_gsum       = r_gsum;
        n_scount     = r_scount;
        n_upd        = 1'b0;
        div_start    = 1'b0;
        case (i_item.cmd)
            CMD_CAL: begin
                n_offset     = '0;
                n_cal_acc    = '0;
                n_cal_idx    = '0;
                n_cal_active = 1'b1;
                n_gsum       = '0;
                n_scount     = '0;
            end
            CMD_CLEAR: begin
                n_gsum   = '0;
                n_scount = '0;
            end
            CMD_SAMPLE: begin
                if (r_cal_active || r_detect_enable) begin
                    for (int i = 0; i < NUM_GYRO; i++) begin
                        if (gwide[i][SUM_W] != gwide[i][SUM_W-1]) begin
                            n_gsum[i] = gwide[i][SUM_W] ? SUM_MIN : SUM_MAX;
                        end else begin
                            n_gsum[i] = gwide[i][SUM_W-1:0];
                        end
                    end
                    n_scount = r_scount + CNT_W'(r_scount != '1);
                    if (r_cal_active) begin
                        n_cal_acc[0] = r_cal_acc[0] + (i_item.accel >>> FRAC_BITS);
                        for (int i = 0; i < NUM_GYRO; i++) begin
                            n_cal_acc[i + 1] = r_cal_acc[i + 1]
                                + ($signed(i_item.gyro[i]) >>> FRAC_BITS);
                        end
                        n_cal_idx = r_cal_idx + CAL_IDX_W'(1);
                        if (n_cal_idx >= CAL_IDX_W'(CAL_SAMPLES)) begin
                            // offsets land when the divider finishes
                            div_start    = pop;
                            n_cal_active = 1'b0;
                            n_gsum       = '0;
                            n_scount     = '0;
                        end
                    end else begin
                        if ((&shifted[ACC_W-1:AVG_W-1]) || !(|shifted[ACC_W-1:AVG_W-1])) begin
                            n_avg = shifted[AVG_W-1:0];
                        end else begin
                            n_avg = shifted[ACC_W-1] ? AVG_MIN : AVG_MAX;
                        end
                        n_upd = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // run length and led, using the average left by the word in the middle slot
    always_comb begin
        thr_fix = {r_tilt_threshold, {FRAC_BITS{1'b0}}};
        below   = (r_avg < thr_fix);
        n_run   = r_run;
        if (r_mid_upd) begin
            if (below) begin
                n_run = r_run + RUN_W'(r_run != '1);
            end else begin
                n_run = '0;
            end
        end
        tilted = (n_run > r_count_limit);
        n_led  = r_led ^ (r_mid_upd && tilted && r_led_enable);

        n_out.pad          = '0;
        n_out.sample_count = r_scount;
        n_out.gyro_sum_z   = r_gsum[2];
        n_out.gyro_sum_y   = r_gsum[1];
        n_out.gyro_sum_x   = r_gsum[0];
        n_out.calibrating  = r_cal_active;
        n_out.led_state    = n_led;
        n_out.tilted       = tilted;
        n_out.below_count  = n_run;
        n_out.mean_tilt    = r_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_gain     <= DECAY_GAIN_RST;
            r_input_gain     <= INPUT_GAIN_RST;
            r_tilt_threshold <= TILT_THRESHOLD_RST;
            r_count_limit    <= COUNT_LIMIT_RST;
            r_led_enable     <= 1'b1;
            r_detect_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DECAY_GAIN:     r_decay_gain     <= i_cfg_data;
                CFG_INPUT_GAIN:     r_input_gain     <= i_cfg_data;
                CFG_TILT_THRESHOLD: r_tilt_threshold <= i_cfg_data;
                CFG_COUNT_LIMIT:    r_count_limit    <= i_cfg_data;
                CFG_LED_ENABLE:     r_led_enable     <= i_cfg_data[0];
                CFG_DETECT_ENABLE:  r_detect_enable  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg        <= '0;
            r_cal_active <= 1'b0;
            r_cal_idx    <= '0;
            r_cal_acc    <= '0;
            r_offset     <= '0;
            r_gsum       <= '0;
            r_scount     <= '0;
            r_mid_valid  <= 1'b0;
            r_mid_upd    <= 1'b0;
        end else begin
            if (pop) begin
                r_avg        <= n_avg;
                r_cal_active <= n_cal_active;
                r_cal_idx    <= n_cal_idx;
                r_cal_acc    <= n_cal_acc;
                r_gsum       <= n_gsum;
                r_scount     <= n_scount;
                r_mid_upd    <= n_upd;
            end
            if (div_stat.done) begin
                r_offset <= div_quot;
            end else if (pop) begin
                r_offset <= n_offset;
            end
            if (pop) begin
                r_mid_valid <= 1'b1;
            end else if (adv) begin
                r_mid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_led       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_mid_valid;
            if (r_mid_valid) begin
                r_run <= n_run;
                r_led <= n_led;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_mid_valid) begin
            r_out <= n_out;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/core/imu_tilt_detector_unit.sv =====
// Tilt detector for raw IMU samples. Each input word (accel Y, gyro X/Y/Z,
// plus a command in tuser) yields exactly one output word showing the state
// after that word: the leaky average of offset-corrected accel Y with 8
// fraction bits, the run of consecutive below-threshold samples, the tilted
// flag, the LED level, the calibration flag, three saturating 56-bit gyro sums
// and a saturating sample count. One word per clock is sustained while the
// output is not stalled and the divider is idle; a result passes the input
// register, queue, execute stage and run-length/output stage. The sample that
// ends calibration starts a shared reciprocal multiplier that computes the four
// offsets one per cycle, so the execute stage takes nothing from the queue
// until the offsets are loaded; the input keeps accepting until the four-deep
// queue and the input register are full. The user must write registers on the
// config port only while no word is in flight; the block does not enforce it.
module imu_tilt_detector_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [itd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // accel_y, gyro_x, gyro_y, gyro_z
    input  logic [itd_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // mean_tilt, below_count, tilted, led_state, calibrating,
    // gyro_sum_x, gyro_sum_y, gyro_sum_z, sample_count, zero fill
    output logic [itd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [itd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [itd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import itd_pkg::*;

    logic    q_ready;
    logic    q_push;
    t_item   q_in;
    logic    q_valid;
    t_item   q_out;
    logic    q_pop;
    t_result result;

    itd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_ready     (q_ready),
        .o_push        (q_push),
        .o_item        (q_in)
    );

    itd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_out),
        .i_pop   (q_pop)
    );

    itd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_item      (q_out),
        .o_pop       (q_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = result;

endmodule

// ===== rtl/core/itd_checker.sv =====
`include "assert_macros.svh"

module itd_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [itd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import itd_pkg::*;

    t_result res;

    assign res = m_axis_tdata;

    `ASSERT_NEXT_ALWAYS(a_reset_empties_output, i_clk, !i_rst_n, !m_axis_tvalid)

    `ASSERT_NEXT(a_word_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    `ASSERT_NEXT(a_word_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // tilted means the run passed the limit, so the run cannot be empty
    `ASSERT_IMPLIES(a_tilted_has_run, i_clk, i_rst_n, m_axis_tvalid && res.tilted, res.below_count != '0)

endmodule

bind imu_tilt_detector_unit itd_checker u_itd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/imu_tilt_detector_unit_test.sv =====
`timescale 1ns / 100ps

module imu_tilt_detector_unit_test;
    import itd_pkg::*;

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 150;
    localparam int REPORT_LIMIT   = 30;

    // input word as it sits on s_axis_tdata, accel Y in the low bits
    typedef struct packed {
        logic signed [RAW_W-1:0] gyro_z;
        logic signed [RAW_W-1:0] gyro_y;
        logic signed [RAW_W-1:0] gyro_x;
        logic signed [RAW_W-1:0] accel_y;
    } t_imu_word;

    class tilt_tracker;
        longint decay_gain, input_gain, threshold, count_limit;
        bit led_en, detect_en;
        longint avg;
        longint run;
        bit led;
        bit cal_on;
        int cal_idx;
        longint cal_sum [NUM_AXES];
        longint offs [NUM_AXES];
        longint gsum [NUM_GYRO];
        longint count;
        t_result expected_reports [$];
        int errors, reports_checked, cal_done, led_toggles;
        longint max_run;

        function new();
            decay_gain  = DECAY_GAIN_RST;
            input_gain  = INPUT_GAIN_RST;
            threshold   = TILT_THRESHOLD_RST;
            count_limit = COUNT_LIMIT_RST;
            led_en      = 1'b1;
            detect_en   = 1'b1;
            avg         = 0;
            run         = 0;
            led         = 1'b0;
            cal_on      = 1'b0;
            cal_idx     = 0;
            foreach (cal_sum[i]) begin
                cal_sum[i] = 0;
                offs[i]    = 0;
            end
            clear_sums();
        endfunction

        function void clear_sums();
            foreach (gsum[i]) gsum[i] = 0;
            count = 0;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DECAY_GAIN:     decay_gain  = val;
                CFG_INPUT_GAIN:     input_gain  = val;
                CFG_TILT_THRESHOLD: threshold   = $signed(val);
                CFG_COUNT_LIMIT:    count_limit = val;
                CFG_LED_ENABLE:     led_en      = val[0];
                CFG_DETECT_ENABLE:  detect_en   = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // advance the detector state by one accepted word and queue the word it reports
        function void take_sample(t_cmd cmd, t_imu_word w);
            longint g [NUM_GYRO];
            longint ay, centred, mix;
            t_result r;
            ay   = w.accel_y;
            g[0] = w.gyro_x;
            g[1] = w.gyro_y;
            g[2] = w.gyro_z;
            case (cmd)
                CMD_CAL: begin
                    foreach (offs[i]) begin
                        offs[i]    = 0;
                        cal_sum[i] = 0;
                    end
                    cal_idx = 0;
                    cal_on  = 1'b1;
                    clear_sums();
                end
                CMD_CLEAR: clear_sums();
                CMD_SAMPLE: begin
                    if (cal_on || detect_en) begin
                        foreach (gsum[i])
                            gsum[i] = clip(gsum[i] + g[i] * 256 - offs[i+1],
                                           longint'(SUM_MIN), longint'(SUM_MAX));
                        if (count != 64'hFFFF_FFFF)
                            count++;
                        if (cal_on) begin
                            cal_sum[0] += ay;
                            foreach (g[i]) cal_sum[i+1] += g[i];
                            cal_idx = (cal_idx + 1) & 8'hFF;
                            if (cal_idx >= CAL_SAMPLES) begin
                                // mean with 8 fraction bits, truncated toward zero
                                foreach (offs[i]) offs[i] = (cal_sum[i] * 256) / CAL_SAMPLES;
                                cal_on = 1'b0;
                                clear_sums();
                                cal_done++;
                            end
                        end else begin
                            centred = ay * 256 - offs[0];
                            mix     = avg * decay_gain + centred * input_gain;
                            avg     = clip(mix >>> GAIN_FRAC, longint'(AVG_MIN),
                                           longint'(AVG_MAX));
                            if (avg < threshold * 256) begin
                                if (run != 16'hFFFF)
                                    run++;
                            end else begin
                                run = 0;
                            end
                            if (run > max_run)
                                max_run = run;
                            if (run > count_limit && led_en) begin
                                led = ~led;
                                led_toggles++;
                            end
                        end
                    end
                end
                default: ;
            endcase
            r              = '0;
            r.mean_tilt    = t_fix'(avg);
            r.below_count  = RUN_W'(run);
            r.tilted       = (run > count_limit);
            r.led_state    = led;
            r.calibrating  = cal_on;
            r.gyro_sum_x   = t_sum'(gsum[0]);
            r.gyro_sum_y   = t_sum'(gsum[1]);
            r.gyro_sum_z   = t_sum'(gsum[2]);
            r.sample_count = CNT_W'(count);
            expected_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s mismatch on output word %0d, expected %0h, got %0h",
                             $time, name, reports_checked, want, got);
            end
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (expected_reports.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: output word with nothing expected, got %0h", $time, got);
                return;
            end
            want = expected_reports.pop_front();
            check_field("mean_tilt", want.mean_tilt, got.mean_tilt);
            check_field("below_count", want.below_count, got.below_count);
            check_field("tilted", want.tilted, got.tilted);
            check_field("led_state", want.led_state, got.led_state);
            check_field("calibrating", want.calibrating, got.calibrating);
            check_field("gyro_sum_x", want.gyro_sum_x, got.gyro_sum_x);
            check_field("gyro_sum_y", want.gyro_sum_y, got.gyro_sum_y);
            check_field("gyro_sum_z", want.gyro_sum_z, got.gyro_sum_z);
            check_field("sample_count", want.sample_count, got.sample_count);
            check_field("zero fill", want.pad, got.pad);
            reports_checked++;
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;  // accel_y, gyro_x, gyro_y, gyro_z
    logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;  // cmd
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // mean_tilt, below_count, tilted, led_state, calibrating,
    // gyro_sum_x, gyro_sum_y, gyro_sum_z, sample_count, zero fill
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    tilt_tracker tracker = new();

    int burst_left = 0;
    int words_sent = 0;
    int settings_used = 0;
    int gyro_bias = 0;

    int rx_period = 1;
    int rx_duty = 1;
    int rx_tick = 0;
    int rx_left = 0;

    imu_tilt_detector_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int spread(int n);
        return int'($urandom_range(0, 2 * n)) - n;
    endfunction

    function automatic logic signed [RAW_W-1:0] sat16(int v);
        return (v > 32767) ? 16'sh7FFF : ((v < -32768) ? 16'sh8000 : RAW_W'(v));
    endfunction

    function automatic t_imu_word make_word(int ay, int gx, int gy, int gz);
        t_imu_word w;
        w.accel_y = sat16(ay);
        w.gyro_x  = sat16(gx);
        w.gyro_y  = sat16(gy);
        w.gyro_z  = sat16(gz);
        return w;
    endfunction

    function automatic t_imu_word noise_word();
        return t_imu_word'({$urandom, $urandom});
    endfunction

    // output side: check every accepted word, stall on a duty pattern that changes now and then
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_report(t_result'(m_axis_tdata));
        if (rx_left == 0) begin
            rx_left = $urandom_range(50, 300);
            if ($urandom_range(0, 2) == 0) begin
                rx_period = 1;
                rx_duty   = 1;
            end else begin
                rx_period = $urandom_range(2, 12);
                rx_duty   = $urandom_range(1, rx_period);
            end
            rx_tick = 0;
        end
        rx_left--;
        rx_tick = (rx_tick + 1) % rx_period;
        m_axis_tready <= (rx_tick < rx_duty);
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no traffic for %0d cycles, %0d output words outstanding",
                 $time, WATCHDOG_LIMIT, tracker.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_word(t_cmd cmd, t_imu_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_sample(cmd, w);
        burst_left--;
        words_sent++;
    endtask

    // wait for every output word, then let the offset divider finish before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
    endtask

    task automatic configure(logic [15:0] decay, logic [15:0] ingain, logic [15:0] thr,
                             logic [15:0] limit, logic led_on, logic det_on);
        write_reg(CFG_DECAY_GAIN, decay);
        write_reg(CFG_INPUT_GAIN, ingain);
        write_reg(CFG_TILT_THRESHOLD, thr);
        write_reg(CFG_COUNT_LIMIT, limit);
        write_reg(CFG_LED_ENABLE, {15'd0, led_on});
        write_reg(CFG_DETECT_ENABLE, {15'd0, det_on});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // a steady sensor with some jitter, now and then interrupted or restarted
    task automatic calibrate_run();
        int ay_bias, gx_bias, gy_bias, gz_bias, pick;
        ay_bias = ($urandom_range(0, 3) == 0) ? spread(32768) : spread(1000);
        gx_bias = ($urandom_range(0, 3) == 0) ? spread(32768) : spread(500);
        gy_bias = spread(500);
        gz_bias = spread(500);
        send_word(CMD_CAL, noise_word());
        while (tracker.cal_on) begin
            pick = $urandom_range(0, 59);
            if (pick == 0)
                send_word(CMD_CAL, noise_word());
            else if (pick == 1)
                send_word(CMD_CLEAR, noise_word());
            else if (pick == 2)
                send_word(CMD_NONE, noise_word());
            else
                send_word(CMD_SAMPLE, make_word(ay_bias + spread(40), gx_bias + spread(40),
                                                gy_bias + spread(40), gz_bias + spread(40)));
        end
    endtask

    // posture segments: level, tilted, upside down, anywhere, pinned at full scale
    task automatic run_phase(int n, bit cal_first);
        int stop_at, seg_left, level, noise, pick;
        t_imu_word w;
        stop_at   = words_sent + n;
        seg_left  = 0;
        level     = 0;
        noise     = 0;
        gyro_bias = spread(1500);
        if (cal_first)
            calibrate_run();
        while (words_sent < stop_at) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(3, 40);
                case ($urandom_range(0, 5))
                    0:       level = 0;
                    1, 2:    level = -16384 + spread(3000);
                    3:       level = 16384;
                    4:       level = spread(32768);
                    default: level = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                endcase
                noise = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
            end
            seg_left--;
            pick = $urandom_range(0, 119);
            if (pick == 0) begin
                calibrate_run();
            end else if (pick < 5) begin
                send_word(CMD_CLEAR, noise_word());
            end else if (pick < 8) begin
                send_word(CMD_NONE, noise_word());
            end else begin
                if ($urandom_range(0, 3) == 0)
                    w = noise_word();
                else
                    w = make_word(0, gyro_bias + spread(200), gyro_bias + spread(200),
                                  gyro_bias + spread(200));
                w.accel_y = sat16(level + spread(noise));
                send_word(CMD_SAMPLE, w);
            end
        end
        drain();
    endtask

    initial begin
        logic [15:0] decay, ingain, thr, limit;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words on the reset settings
        send_word(CMD_SAMPLE, make_word(32767, 32767, -32768, 0));
        send_word(CMD_SAMPLE, make_word(-32768, -32768, 32767, -1));
        send_word(CMD_SAMPLE, make_word(-32768, 1, -1, 32767));
        send_word(CMD_NONE, noise_word());
        send_word(CMD_CLEAR, noise_word());
        send_word(CMD_SAMPLE, make_word(0, 0, 0, 0));
        send_word(CMD_CAL, noise_word());
        send_word(CMD_SAMPLE, make_word(-100, 7, -7, 3));
        send_word(CMD_SAMPLE, make_word(-99, 9, -8, 2));
        send_word(CMD_SAMPLE, make_word(-101, 6, -6, 3));
        // restart while gathering
        send_word(CMD_CAL, noise_word());
        send_word(CMD_SAMPLE, make_word(-3, 1, -1, 0));
        send_word(CMD_CLEAR, noise_word());
        send_word(CMD_NONE, noise_word());
        send_word(CMD_SAMPLE, make_word(-2, 2, -3, -1));
        send_word(CMD_SAMPLE, make_word(-4, 1, -2, 1));
        drain();

        configure(16'd0, 16'd32768, 16'h8000, 16'd0, 1'b1, 1'b1);
        run_phase(PHASE_WORDS, 1'b0);
        configure(16'd32768, 16'd32768, 16'h7FFF, 16'hFFFF, 1'b0, 1'b1);
        run_phase(PHASE_WORDS, 1'b1);
        configure(DECAY_GAIN_RST, INPUT_GAIN_RST, TILT_THRESHOLD_RST, COUNT_LIMIT_RST,
                  1'b1, 1'b1);
        run_phase(PHASE_WORDS, 1'b1);
        // detection off: plain samples are dropped but calibration still runs
        configure(DECAY_GAIN_RST, INPUT_GAIN_RST, TILT_THRESHOLD_RST, COUNT_LIMIT_RST,
                  1'b1, 1'b0);
        run_phase(60, 1'b1);
        configure(16'hFFFF, 16'hFFFF, 16'd0, 16'd3, 1'b1, 1'b1);
        run_phase(PHASE_WORDS, 1'b0);
        repeat (6) begin
            decay  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            ingain = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            thr    = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'(spread(2000));
            limit  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            configure(decay, ingain, thr, limit, 1'($urandom), $urandom_range(0, 7) != 0);
            run_phase(PHASE_WORDS, $urandom_range(0, 1) != 0);
        end

        $display("%0d input words over %0d register settings, %0d calibrations completed",
                 words_sent, settings_used, tracker.cal_done);
        $display("%0d output words checked, longest tilt run %0d, %0d led toggles",
                 tracker.reports_checked, tracker.max_run, tracker.led_toggles);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
